// ----- rtl/power_sequencer_with_shutdown_assert.svh -----
// ----------------------------------------------------------------------------
// Power sequencer assertion macros
// Shared shorthand for the concurrent checks of the power sequencer.
// ----------------------------------------------------------------------------
`ifndef POWER_SEQUENCER_WITH_SHUTDOWN_ASSERT_SVH
`define POWER_SEQUENCER_WITH_SHUTDOWN_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define PWRSEQ_ASSERT_SAME(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("power sequencer check failed: %m");

// antecedent implies consequent in the next cycle
`define PWRSEQ_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("power sequencer check failed: %m");

`endif

// ----- rtl/pwrseq_pkg.sv -----
// ----------------------------------------------------------------------------
// Power sequencer package
// Types and constants shared by the power sequencer modules.
// ----------------------------------------------------------------------------
package pwrseq_pkg;

   localparam int PRESS_W    = 16;
   localparam int TIMEOUT_W  = 20;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [PRESS_W-1:0]   KEY_PRESS_RESET = 16'd100;
   localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET   = 20'd30000;

   // register select, taken from the word address bit
   localparam logic REG_KEY_PRESS = 1'b0;
   localparam logic REG_TIMEOUT   = 1'b1;

   typedef enum logic [2:0] {
      CMD_TICK     = 3'd0,
      CMD_OFF      = 3'd1,
      CMD_ON       = 3'd2,
      CMD_SHUTDOWN = 3'd3,
      CMD_TOGGLE   = 3'd4
   } cmd_type;

   typedef enum logic [1:0] {
      STATUS_OFF      = 2'd0,
      STATUS_ON       = 2'd1,
      STATUS_SHUTDOWN = 2'd2
   } status_type;

   typedef struct packed {
      logic [PRESS_W-1:0]   key_press_ticks;
      logic [TIMEOUT_W-1:0] shutdown_timeout_ticks;
   } cfg_type;

   typedef struct packed {
      cmd_type command;
      logic    sense_high;
   } item_type;

   typedef struct packed {
      status_type status;
      logic       key_asserted;
      logic       power_enable;
   } result_type;

endpackage

// ----- rtl/pwrseq_csr.sv -----
// ----------------------------------------------------------------------------
// Power sequencer register file
// APB-style access to the key press length and shutdown timeout registers.
// ----------------------------------------------------------------------------
module pwrseq_csr (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [pwrseq_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [pwrseq_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [pwrseq_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                  csr_pready,
   output pwrseq_pkg::cfg_type                   cfg
);
   import pwrseq_pkg::*;

   logic [PRESS_W-1:0]   key_press_ff;
   logic [PRESS_W-1:0]   key_press_in;
   logic [TIMEOUT_W-1:0] timeout_ff;
   logic [TIMEOUT_W-1:0] timeout_in;
   logic                 wr_en;
   logic                 reg_sel;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign reg_sel    = csr_paddr[2];

   // write decode
   always_comb begin
      key_press_in = key_press_ff;
      timeout_in   = timeout_ff;
      if (wr_en) begin
         unique case (reg_sel)
            REG_KEY_PRESS: key_press_in = csr_pwdata[PRESS_W-1:0];
            REG_TIMEOUT:   timeout_in   = csr_pwdata[TIMEOUT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_press_ff <= KEY_PRESS_RESET;
         timeout_ff   <= TIMEOUT_RESET;
      end else begin
         key_press_ff <= key_press_in;
         timeout_ff   <= timeout_in;
      end
   end

   // read mux
   always_comb begin
      unique case (reg_sel)
         REG_KEY_PRESS: csr_prdata = {{(CSR_DATA_W-PRESS_W){1'b0}}, key_press_ff};
         REG_TIMEOUT:   csr_prdata = {{(CSR_DATA_W-TIMEOUT_W){1'b0}}, timeout_ff};
         default:       csr_prdata = '0;
      endcase
   end

   assign cfg.key_press_ticks        = key_press_ff;
   assign cfg.shutdown_timeout_ticks = timeout_ff;

endmodule

// ----- rtl/pwrseq_core.sv -----
// ----------------------------------------------------------------------------
// Power sequencer core
// Power state, key press and timeout timers, and the result register.
// ----------------------------------------------------------------------------
`include "power_sequencer_with_shutdown_assert.svh"

module pwrseq_core (
   input  logic                   clock,
   input  logic                   reset,
   input  pwrseq_pkg::cfg_type    cfg,
   input  logic                   step_valid,
   input  pwrseq_pkg::item_type   item,
   output logic                   step_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output pwrseq_pkg::result_type result
);
   import pwrseq_pkg::*;

   logic                 power_on_ff, power_on_in;
   logic                 shutting_down_ff, shutting_down_in;
   logic                 key_held_ff, key_held_in;
   logic [PRESS_W-1:0]   press_timer_ff, press_timer_in;
   logic [TIMEOUT_W-1:0] shutdown_timer_ff, shutdown_timer_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   result_type           result_ff, result_in;

   logic                 step_fire;
   logic [PRESS_W-1:0]   press_inc;
   logic [TIMEOUT_W-1:0] timeout_inc;
   logic                 press_expire;
   logic                 timeout_expire;
   logic                 do_on, do_off, do_shutdown;

   // result slot frees when empty or being drained
   assign step_ready = !rsp_valid_ff || rsp_ready;
   assign step_fire  = step_valid && step_ready;

   // saturating timer advance and expiry
   assign press_inc      = (press_timer_ff == '1) ? press_timer_ff
                                                  : press_timer_ff + {{(PRESS_W-1){1'b0}}, 1'b1};
   assign timeout_inc    = (shutdown_timer_ff == '1) ? shutdown_timer_ff
                           : shutdown_timer_ff + {{(TIMEOUT_W-1){1'b0}}, 1'b1};
   assign press_expire   = press_inc >= cfg.key_press_ticks;
   assign timeout_expire = timeout_inc >= cfg.shutdown_timeout_ticks;

   // command decode, toggle folded in
   always_comb begin
      do_on       = 1'b0;
      do_off      = 1'b0;
      do_shutdown = 1'b0;
      unique case (item.command)
         CMD_OFF:      do_off = 1'b1;
         CMD_ON:       do_on = 1'b1;
         CMD_SHUTDOWN: do_shutdown = 1'b1;
         CMD_TOGGLE: begin
            if (!power_on_ff) begin
               do_on = 1'b1;
            end else if (!shutting_down_ff) begin
               do_shutdown = 1'b1;
            end else begin
               do_off = 1'b1;
            end
         end
         default: ;
      endcase
   end

   // next state
   always_comb begin
      power_on_in       = power_on_ff;
      shutting_down_in  = shutting_down_ff;
      key_held_in       = key_held_ff;
      press_timer_in    = press_timer_ff;
      shutdown_timer_in = shutdown_timer_ff;
      if (step_fire) begin
         if (item.command == CMD_TICK) begin
            press_timer_in    = press_expire ? '0 : press_inc;
            shutdown_timer_in = timeout_expire ? '0 : timeout_inc;
            if (press_expire) begin
               key_held_in = 1'b0;
            end
            // sense line or timeout ends a shutdown
            if (shutting_down_ff && (item.sense_high || timeout_expire)) begin
               power_on_in      = 1'b0;
               shutting_down_in = 1'b0;
            end
         end
         if (do_off) begin
            power_on_in      = 1'b0;
            shutting_down_in = 1'b0;
         end
         if (do_on) begin
            power_on_in      = 1'b1;
            shutting_down_in = 1'b0;
            key_held_in      = 1'b0;
         end
         if (do_shutdown) begin
            key_held_in       = 1'b1;
            press_timer_in    = '0;
            shutting_down_in  = 1'b1;
            shutdown_timer_in = '0;
         end
      end
   end

   // result from the updated state
   always_comb begin
      result_in.power_enable = power_on_in;
      result_in.key_asserted = key_held_in;
      if (!power_on_in) begin
         result_in.status = STATUS_OFF;
      end else if (shutting_down_in) begin
         result_in.status = STATUS_SHUTDOWN;
      end else begin
         result_in.status = STATUS_ON;
      end
   end

   assign rsp_valid_in = step_fire || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         power_on_ff       <= 1'b0;
         shutting_down_ff  <= 1'b0;
         key_held_ff       <= 1'b0;
         press_timer_ff    <= '0;
         shutdown_timer_ff <= '0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         power_on_ff       <= power_on_in;
         shutting_down_ff  <= shutting_down_in;
         key_held_ff       <= key_held_in;
         press_timer_ff    <= press_timer_in;
         shutdown_timer_ff <= shutdown_timer_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   // result payload, loaded per beat
   always_ff @(posedge clock) begin
      if (step_fire) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign result    = result_ff;

   `PWRSEQ_ASSERT_NEXT(a_on_cmd, clock, reset,
      step_fire && item.command == CMD_ON,
      power_on_ff && !shutting_down_ff && !key_held_ff)
   `PWRSEQ_ASSERT_NEXT(a_shutdown_cmd, clock, reset,
      step_fire && item.command == CMD_SHUTDOWN,
      key_held_ff && shutting_down_ff && press_timer_ff == '0 && shutdown_timer_ff == '0)
   `PWRSEQ_ASSERT_NEXT(a_sense_off, clock, reset,
      step_fire && item.command == CMD_TICK && shutting_down_ff && item.sense_high,
      !shutting_down_ff && !power_on_ff)
   `PWRSEQ_ASSERT_SAME(a_status_match, clock, reset,
      rsp_valid_ff,
      result_ff.power_enable == (result_ff.status != STATUS_OFF))
   `PWRSEQ_ASSERT_NEXT(a_result_state, clock, reset,
      step_fire,
      result_ff.power_enable == power_on_ff && result_ff.key_asserted == key_held_ff)

endmodule

// ----- rtl/power_sequencer_with_shutdown.sv -----
// A beat accepted is held in the input register, then its result in the result register.
// Throughput: one beat per cycle while rsp_tready is high; the input register and the
// result register keep both sides moving, the state update is a single pass between them.
// Reset (synchronous, active high): power off, key released, timers at zero,
// key press length 100 ticks and shutdown timeout 30000 ticks.
// ----------------------------------------------------------------------------
// Power sequencer with shutdown
// Top level: input register, power state core and register file.
// ----------------------------------------------------------------------------
module power_sequencer_with_shutdown (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [7:0]                            req_tdata,  // [0] sense_high, zero fill
   input  logic [2:0]                            req_tuser,  // [2:0] command
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [7:0]                            rsp_tdata,  // [0] power_enable,
                                                              // [1] key_asserted,
                                                              // [3:2] status, zero fill
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [pwrseq_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [pwrseq_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [pwrseq_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                  csr_pready
);
   import pwrseq_pkg::*;

   cfg_type    cfg;
   item_type   item_ff, item_in;
   logic       in_valid_ff, in_valid_in;
   logic       step_ready;
   logic       req_fire;
   result_type result;

   pwrseq_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // input register
   assign req_tready  = !in_valid_ff || step_ready;
   assign req_fire    = req_tvalid && req_tready;
   assign in_valid_in = req_fire || (in_valid_ff && !step_ready);

   assign item_in.command    = cmd_type'(req_tuser);
   assign item_in.sense_high = req_tdata[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         item_ff <= item_in;
      end
   end

   pwrseq_core u_core (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .step_valid (in_valid_ff),
      .item       (item_ff),
      .step_ready (step_ready),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .result     (result)
   );

   assign rsp_tdata = {4'b0000, result.status, result.key_asserted, result.power_enable};

endmodule
